// ===== design/qmr_pkg.sv =====
// Shared types, codes and a helper function for the queue with minimum removal and interleave.
`timescale 1ns / 1ps
`default_nettype none

package qmr_pkg;

   localparam int DEPTH      = 16;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   localparam logic [2:0] FN_ENQ        = 3'd0;
   localparam logic [2:0] FN_DEQ        = 3'd1;
   localparam logic [2:0] FN_CONTAINS   = 3'd2;
   localparam logic [2:0] FN_RM_ALL     = 3'd3;
   localparam logic [2:0] FN_RM_LAST    = 3'd4;
   localparam logic [2:0] FN_INTERLEAVE = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]                   func;
      logic signed [VALUE_BITS-1:0] item_value;
   } req_item_type;

   typedef struct packed {
      logic                         hit;
      logic signed [VALUE_BITS-1:0] out_value;
      logic [CNT_BITS-1:0]          entry_total;
      logic [1:0]                   status;
   } rsp_item_type;

   // Ring position of the entry that lies offs places behind the head.
   function automatic logic [IDX_BITS-1:0] slot(input logic [IDX_BITS-1:0] head,
                                                input logic [IDX_BITS-1:0] offs);
      logic [IDX_BITS:0] sum;
      sum = {1'b0, head} + {1'b0, offs};
      if (sum >= (IDX_BITS + 1)'(DEPTH)) begin
         sum = sum - (IDX_BITS + 1)'(DEPTH);
      end
      return sum[IDX_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/qmr_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module qmr_ram #(
   parameter int DEPTH_P = 16,
   parameter int WIDTH_P = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH_P)-1:0] wr_addr,
   input  wire logic [WIDTH_P-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH_P)-1:0] rd_addr,
   output logic      [WIDTH_P-1:0]         rd_data
);

   logic [WIDTH_P-1:0] mem [DEPTH_P];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/queue_with_min_removal_and_interleave_top.sv =====
// Bounded queue of signed values with search, minimum removal and interleave.
//
// An item is taken on req_item at a rising clock edge where start is high and
// busy is low. It carries an operation code and a value. Every item produces
// exactly one result on rsp_item, shown for one cycle while rsp_valid is high.
// The receiver cannot stall, so results are never held back.
// Entries live in a ring inside one synchronous RAM; a second RAM serves as a
// work buffer when entries are compacted or reordered. An enqueue, an operation
// on an empty queue or an unused code gives its result in the cycle after
// acceptance; a dequeue first reads the head entry in the S_DEQ state. Contains
// scans the ring with one RAM read per cycle. Interleave streams through both
// RAMs in turn, from the entry RAM into the work buffer and back again. The
// two minimum removals add a search pass for the minimum first. The
// sequencer handles one item at a time, and busy stays high until the result
// is issued; a new item may be accepted in the cycle that shows the result.
// Reset empties the queue; RAM contents are not cleared and are never read
// before being written.
`timescale 1ns / 1ps
`default_nettype none

module queue_with_min_removal_and_interleave_top
   import qmr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEQ  = 3'd1;
   localparam logic [2:0] S_MIN  = 3'd2;
   localparam logic [2:0] S_MAIN = 3'd3;
   localparam logic [2:0] S_COPY = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [2:0]                   func_ff, func_in;
   logic signed [VALUE_BITS-1:0] val_ff, val_in;
   logic signed [VALUE_BITS-1:0] min_ff, min_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]          keep_ff, keep_in;
   logic [CNT_BITS-1:0]          half_ff, half_in;
   logic [CNT_BITS-1:0]          rd_cnt_ff, rd_cnt_in;
   logic [IDX_BITS-1:0]          head_ff, head_in;
   logic [IDX_BITS-1:0]          last_ff, last_in;
   logic [IDX_BITS-1:0]          rd_idx_ff, rd_idx_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic                         hit_ff, hit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_item_type                 rsp_ff, rsp_in;

   logic [CNT_BITS-1:0]          len;
   logic [CNT_BITS-1:0]          src_pos;
   logic [CNT_BITS:0]            half_calc;
   logic [IDX_BITS-1:0]          src_idx;
   logic                         issue;
   logic                         last_beat;

   logic                         ent_we;
   logic [IDX_BITS-1:0]          ent_waddr;
   logic [VALUE_BITS-1:0]        ent_wdata;
   logic [IDX_BITS-1:0]          ent_raddr;
   logic [VALUE_BITS-1:0]        ent_rdata;
   logic                         scr_we;
   logic [IDX_BITS-1:0]          scr_waddr;
   logic [VALUE_BITS-1:0]        scr_wdata;
   logic [IDX_BITS-1:0]          scr_raddr;
   logic [VALUE_BITS-1:0]        scr_rdata;

   qmr_ram #(
      .DEPTH_P(DEPTH),
      .WIDTH_P(VALUE_BITS)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ent_we),
      .wr_addr(ent_waddr),
      .wr_data(ent_wdata),
      .rd_addr(ent_raddr),
      .rd_data(ent_rdata)
   );

   qmr_ram #(
      .DEPTH_P(DEPTH),
      .WIDTH_P(VALUE_BITS)
   ) u_scratch_ram (
      .clock  (clock),
      .wr_en  (scr_we),
      .wr_addr(scr_waddr),
      .wr_data(scr_wdata),
      .rd_addr(scr_raddr),
      .rd_data(scr_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign len       = (state_ff == S_COPY) ? keep_ff : cnt_ff;
   assign issue     = ((state_ff == S_MIN) || (state_ff == S_MAIN) || (state_ff == S_COPY))
                      && (rd_cnt_ff < len);
   assign last_beat = rd_vld_ff && (CNT_BITS'(rd_idx_ff) == (len - CNT_BITS'(1)));
   assign half_calc = ((CNT_BITS + 1)'(cnt_ff) + (CNT_BITS + 1)'(1)) >> 1;

   // Interleave reads the front half and the back half alternately.
   always_comb begin
      if ((state_ff == S_MAIN) && (func_ff == FN_INTERLEAVE)) begin
         if (rd_cnt_ff[0]) begin
            src_pos = half_ff + (rd_cnt_ff >> 1);
         end else begin
            src_pos = rd_cnt_ff >> 1;
         end
      end else begin
         src_pos = rd_cnt_ff;
      end
   end

   assign src_idx   = src_pos[IDX_BITS-1:0];
   assign ent_raddr = (state_ff == S_IDLE) ? head_ff : slot(head_ff, src_idx);
   assign scr_raddr = rd_cnt_ff[IDX_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      val_in       = val_ff;
      min_in       = min_ff;
      cnt_in       = cnt_ff;
      keep_in      = keep_ff;
      half_in      = half_ff;
      head_in      = head_ff;
      last_in      = last_ff;
      hit_in       = hit_ff;
      rd_vld_in    = issue;
      rd_idx_in    = rd_cnt_ff[IDX_BITS-1:0];
      rd_cnt_in    = issue ? (rd_cnt_ff + CNT_BITS'(1)) : rd_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rsp_in.hit       = 1'b0;
      rsp_in.out_value = '0;
      rsp_in.status    = ST_OK;
      ent_we       = 1'b0;
      ent_waddr    = slot(head_ff, cnt_ff[IDX_BITS-1:0]);
      ent_wdata    = req_item.item_value;
      scr_we       = 1'b0;
      scr_waddr    = keep_ff[IDX_BITS-1:0];
      scr_wdata    = ent_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in   = req_item.func;
               val_in    = req_item.item_value;
               rd_cnt_in = '0;
               keep_in   = '0;
               hit_in    = 1'b0;
               half_in   = half_calc[CNT_BITS-1:0];
               if (req_item.func == FN_ENQ) begin
                  rsp_valid_in = 1'b1;
                  if (cnt_ff == CNT_BITS'(DEPTH)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     ent_we = 1'b1;
                     cnt_in = cnt_ff + CNT_BITS'(1);
                  end
               end else if (req_item.func inside {FN_DEQ, FN_CONTAINS, FN_RM_ALL,
                                                  FN_RM_LAST, FN_INTERLEAVE}) begin
                  if (cnt_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_EMPTY;
                  end else if (req_item.func == FN_DEQ) begin
                     state_in = S_DEQ;
                  end else if ((req_item.func == FN_RM_ALL) ||
                               (req_item.func == FN_RM_LAST)) begin
                     state_in = S_MIN;
                  end else begin
                     state_in = S_MAIN;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_DEQ: begin
            rsp_valid_in     = 1'b1;
            rsp_in.hit       = 1'b1;
            rsp_in.out_value = $signed(ent_rdata);
            head_in          = slot(head_ff, IDX_BITS'(1));
            cnt_in           = cnt_ff - CNT_BITS'(1);
            state_in         = S_IDLE;
         end
         S_MIN: begin
            if (rd_vld_ff) begin
               if ((rd_idx_ff == '0) || ($signed(ent_rdata) < min_ff)) begin
                  min_in  = $signed(ent_rdata);
                  last_in = rd_idx_ff;
               end else if ($signed(ent_rdata) == min_ff) begin
                  last_in = rd_idx_ff;
               end
            end
            if (last_beat) begin
               state_in  = S_MAIN;
               rd_cnt_in = '0;
            end
         end
         S_MAIN: begin
            if (rd_vld_ff) begin
               case (func_ff)
                  FN_CONTAINS: begin
                     if ($signed(ent_rdata) == val_ff) begin
                        hit_in = 1'b1;
                     end
                  end
                  FN_RM_ALL: begin
                     if ($signed(ent_rdata) != min_ff) begin
                        scr_we  = 1'b1;
                        keep_in = keep_ff + CNT_BITS'(1);
                     end
                  end
                  FN_RM_LAST: begin
                     if (rd_idx_ff != last_ff) begin
                        scr_we  = 1'b1;
                        keep_in = keep_ff + CNT_BITS'(1);
                     end
                  end
                  default: begin
                     scr_we  = 1'b1;
                     keep_in = keep_ff + CNT_BITS'(1);
                  end
               endcase
            end
            if (last_beat) begin
               if (func_ff == FN_CONTAINS) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.hit   = hit_in;
                  state_in     = S_IDLE;
               end else if (keep_in == '0) begin
                  rsp_valid_in = 1'b1;
                  cnt_in       = '0;
                  state_in     = S_IDLE;
               end else begin
                  state_in  = S_COPY;
                  rd_cnt_in = '0;
               end
            end
         end
         S_COPY: begin
            if (rd_vld_ff) begin
               ent_we    = 1'b1;
               ent_waddr = slot(head_ff, rd_idx_ff);
               ent_wdata = scr_rdata;
            end
            if (last_beat) begin
               rsp_valid_in = 1'b1;
               cnt_in       = keep_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.entry_total = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         head_ff      <= '0;
         rd_cnt_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      val_ff    <= val_in;
      min_ff    <= min_in;
      keep_ff   <= keep_in;
      half_ff   <= half_in;
      last_ff   <= last_in;
      hit_ff    <= hit_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("An accepted item neither responded nor kept the block busy.");

   a_full_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == ST_FULL)) |-> (rsp_item.entry_total == CNT_BITS'(DEPTH)))
      else $error("A refused enqueue reported a queue that is not full.");

   a_keep_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MAIN) || (state_ff == S_COPY)) |-> (keep_ff <= cnt_ff))
      else $error("Compaction kept more entries than the queue holds.");

   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("A result was issued while an item is still in progress.");

endmodule

`default_nettype wire

// ===== bench/queue_with_min_removal_and_interleave_top_tb.sv =====
// Testbench for the queue with minimum removal and interleave: directed and random items.
`timescale 1ns / 1ps

module queue_with_min_removal_and_interleave_top_tb
   import qmr_pkg::*;
();

   localparam logic [2:0] FN_SPARE_A = 3'd6;
   localparam logic [2:0] FN_SPARE_B = 3'd7;
   localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 80;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   logic signed [VALUE_BITS-1:0] held_entries[$];
   rsp_item_type                 awaited_rsp[$];
   int                           error_count = 0;
   int                           quiet_cycles = 0;
   bit                           gaps_enabled = 1'b1;

   queue_with_min_removal_and_interleave_top uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one operation to the expected queue contents and returns its result.
   function automatic rsp_item_type apply_queue_op(input req_item_type op);
      rsp_item_type                 r;
      logic signed [VALUE_BITS-1:0] lowest;
      logic signed [VALUE_BITS-1:0] rebuilt[$];
      int                           n;
      int                           half;
      int                           last_pos;
      r = '0;
      r.status = ST_OK;
      n = held_entries.size();
      if (op.func == FN_ENQ) begin
         if (n >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            held_entries.push_back(op.item_value);
         end
      end else if (op.func > FN_INTERLEAVE) begin
         r.status = ST_OK;
      end else if (n == 0) begin
         r.status = ST_EMPTY;
      end else begin
         case (op.func)
            FN_DEQ: begin
               r.hit = 1'b1;
               r.out_value = held_entries.pop_front();
            end
            FN_CONTAINS: begin
               foreach (held_entries[i]) begin
                  if (held_entries[i] == op.item_value) r.hit = 1'b1;
               end
            end
            FN_RM_ALL, FN_RM_LAST: begin
               lowest = held_entries[0];
               foreach (held_entries[i]) begin
                  if (held_entries[i] < lowest) lowest = held_entries[i];
               end
               if (op.func == FN_RM_ALL) begin
                  foreach (held_entries[i]) begin
                     if (held_entries[i] != lowest) rebuilt.push_back(held_entries[i]);
                  end
                  held_entries = rebuilt;
               end else begin
                  last_pos = 0;
                  foreach (held_entries[i]) begin
                     if (held_entries[i] == lowest) last_pos = i;
                  end
                  held_entries.delete(last_pos);
               end
            end
            FN_INTERLEAVE: begin
               half = (n + 1) / 2;
               for (int i = 0; i < half; i++) begin
                  rebuilt.push_back(held_entries[i]);
                  if (half + i < n) rebuilt.push_back(held_entries[half + i]);
               end
               held_entries = rebuilt;
            end
            default: begin
            end
         endcase
      end
      r.entry_total = CNT_BITS'(held_entries.size());
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (!gaps_enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return VALUE_BITS'($signed($urandom_range(0, 8)) - 4);
      if (roll == 4) return MOST_NEG;
      if (roll == 5) return MOST_POS;
      return $urandom;
   endfunction

   task automatic issue_op(input logic [2:0] func, input logic signed [VALUE_BITS-1:0] value);
      req_item_type op;
      int           gap;
      op.func = func;
      op.item_value = value;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_item <= op;
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_rsp.push_back(apply_queue_op(op));
   endtask

   task automatic test_empty_queue();
      issue_op(FN_DEQ, 32'sd7);
      issue_op(FN_CONTAINS, 32'sd0);
      issue_op(FN_RM_ALL, 32'sd0);
      issue_op(FN_RM_LAST, 32'sd0);
      issue_op(FN_INTERLEAVE, 32'sd0);
      issue_op(FN_SPARE_A, MOST_POS);
      issue_op(FN_SPARE_B, MOST_NEG);
   endtask

   task automatic test_single_entry_interleave();
      issue_op(FN_ENQ, 32'sd5);
      issue_op(FN_INTERLEAVE, 32'sd0);
   endtask

   task automatic test_extremes_and_ties();
      issue_op(FN_ENQ, MOST_NEG);
      issue_op(FN_ENQ, MOST_POS);
      issue_op(FN_ENQ, MOST_NEG);
      issue_op(FN_ENQ, -32'sd1);
      issue_op(FN_CONTAINS, MOST_POS);
      issue_op(FN_CONTAINS, 32'sd0);
      issue_op(FN_RM_LAST, 32'sd0);
      issue_op(FN_ENQ, MOST_NEG);
      issue_op(FN_RM_ALL, 32'sd0);
      issue_op(FN_INTERLEAVE, 32'sd0);
      issue_op(FN_DEQ, 32'sd0);
   endtask

   // Rounds lean toward filling, draining or a mix, so the queue swings between full and empty.
   task automatic test_random_traffic(input int item_target);
      int                           sent;
      int                           round_len;
      int                           enq_pct;
      int                           roll;
      logic [2:0]                   func;
      logic signed [VALUE_BITS-1:0] value;
      sent = 0;
      while (sent < item_target) begin
         case ($urandom_range(0, 2))
            0: enq_pct = 70;
            1: enq_pct = 15;
            default: enq_pct = 40;
         endcase
         gaps_enabled = ($urandom_range(0, 3) != 0);
         round_len = $urandom_range(15, 60);
         repeat (round_len) begin
            value = pick_value();
            if ($urandom_range(0, 99) < enq_pct) begin
               func = FN_ENQ;
            end else begin
               roll = $urandom_range(0, 19);
               if (roll < 7) func = FN_DEQ;
               else if (roll < 11) func = FN_CONTAINS;
               else if (roll < 14) func = FN_RM_ALL;
               else if (roll < 17) func = FN_RM_LAST;
               else if (roll < 19) func = FN_INTERLEAVE;
               else func = $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
            end
            if (func == FN_CONTAINS && held_entries.size() > 0 && $urandom_range(0, 9) < 6) begin
               value = held_entries[$urandom_range(0, held_entries.size() - 1)];
            end
            issue_op(func, value);
            sent++;
         end
      end
      gaps_enabled = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_rsp.size() == 0) begin
            $error("unexpected result: hit %0b value %0d total %0d status %0d",
                   rsp_item.hit, rsp_item.out_value, rsp_item.entry_total, rsp_item.status);
            error_count++;
         end else begin
            rsp_item_type want;
            want = awaited_rsp.pop_front();
            if (rsp_item.hit !== want.hit) begin
               $error("hit: expected %0b, got %0b", want.hit, rsp_item.hit);
               error_count++;
            end
            if (rsp_item.out_value !== want.out_value) begin
               $error("out_value: expected %0d, got %0d", want.out_value, rsp_item.out_value);
               error_count++;
            end
            if (rsp_item.entry_total !== want.entry_total) begin
               $error("entry_total: expected %0d, got %0d", want.entry_total,
                      rsp_item.entry_total);
               error_count++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_single_entry_interleave();
      test_extremes_and_ties();
      test_random_traffic(1080);

      @(negedge clock);
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== queue_with_min_removal_and_interleave_top.f =====
design/qmr_pkg.sv
design/qmr_ram.sv
design/queue_with_min_removal_and_interleave_top.sv
bench/queue_with_min_removal_and_interleave_top_tb.sv
